/* rtl/pmid_pkg.sv */
package pmid_pkg;

    localparam int AXES       = 3;
    localparam int MAX_AXES   = 3;
    localparam int COORD_W    = 32;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int LEN_W      = 31;
    localparam int HALF_W     = LEN_W - 1;
    localparam int MASK_W     = 3;
    localparam int MAG_W      = COORD_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int ROOT_REM_W = ROOT_W + 3;
    localparam int FOLD_STEPS = DELTA_W;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(65536);
    localparam logic [MASK_W-1:0] WRAP_RESET = '0;

    typedef enum logic [1:0] {
        REG_LEN_X = 2'd0,
        REG_LEN_Y = 2'd1,
        REG_LEN_Z = 2'd2,
        REG_WRAP  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MAX_AXES-1:0][LEN_W-1:0] len;
        logic [MASK_W-1:0]              wrap;
    } cfg_t;

endpackage

/* rtl/pmid_regs.sv */
module pmid_regs import pmid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [MAX_AXES-1:0][LEN_W-1:0] len_reg;
    logic [MASK_W-1:0]              wrap_reg;
    reg_idx_t                       idx;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_AXES; i++) begin
                len_reg[i] <= LEN_RESET;
            end
            wrap_reg <= WRAP_RESET;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_LEN_X: len_reg[0] <= pwdata[LEN_W-1:0];
                REG_LEN_Y: len_reg[1] <= pwdata[LEN_W-1:0];
                REG_LEN_Z: len_reg[2] <= pwdata[LEN_W-1:0];
                REG_WRAP:  wrap_reg   <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LEN_X: prdata = DATA_W'(len_reg[0]);
            REG_LEN_Y: prdata = DATA_W'(len_reg[1]);
            REG_LEN_Z: prdata = DATA_W'(len_reg[2]);
            REG_WRAP:  prdata = DATA_W'(wrap_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.len  = len_reg;
    assign cfg.wrap = wrap_reg;

endmodule

/* rtl/pmid_fold.sv */
module pmid_fold import pmid_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DELTA_W-1:0] in_delta,
    input  logic [LEN_W-1:0]   len,
    input  logic               wrap,
    output logic               out_valid,
    output logic [DELTA_W-1:0] out_delta
);

    function automatic logic [LEN_W-1:0] rem_step(input logic [LEN_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [LEN_W-1:0] l);
        logic [LEN_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, l}) begin
            t = t - {1'b0, l};
        end
        return t[LEN_W-1:0];
    endfunction

    logic                wrap_on;
    logic [HALF_W-1:0]   half;

    logic                m0_vld_reg;
    logic [DELTA_W:0]    m0_x_reg;
    logic [DELTA_W-1:0]  m0_delta_reg;
    logic [DELTA_W:0]    m0_x_next;

    logic                m1_vld_reg;
    logic [DELTA_W-1:0]  m1_mag_reg;
    logic                m1_neg_reg;
    logic [DELTA_W-1:0]  m1_delta_reg;
    logic [DELTA_W:0]    m1_mag_next;

    logic                dv_vld_reg   [FOLD_STEPS];
    logic [LEN_W-1:0]    dv_rem_reg   [FOLD_STEPS];
    logic [DELTA_W-1:0]  dv_quo_reg   [FOLD_STEPS];
    logic                dv_neg_reg   [FOLD_STEPS];
    logic [DELTA_W-1:0]  dv_delta_reg [FOLD_STEPS];

    logic                f1_vld_reg;
    logic [LEN_W-1:0]    f1_r_reg;
    logic [DELTA_W-1:0]  f1_delta_reg;
    logic [LEN_W-1:0]    f1_r_next;

    logic                f2_vld_reg;
    logic [DELTA_W-1:0]  f2_out_reg;
    logic [DELTA_W-1:0]  f2_out_next;

    assign wrap_on = wrap && (len != '0);
    assign half    = len[LEN_W-1:1];

    assign m0_x_next   = {in_delta[DELTA_W-1], in_delta} + (DELTA_W+1)'(half);
    assign m1_mag_next = m0_x_reg[DELTA_W] ? (~m0_x_reg + 1'b1) : m0_x_reg;

    // negative dividend: positive modulo is len - r unless r is zero
    assign f1_r_next = (dv_neg_reg[FOLD_STEPS-1] && dv_rem_reg[FOLD_STEPS-1] != '0)
                       ? (len - dv_rem_reg[FOLD_STEPS-1]) : dv_rem_reg[FOLD_STEPS-1];

    assign f2_out_next = wrap_on ? ({2'b00, f1_r_reg} - DELTA_W'(half)) : f1_delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m0_vld_reg <= 1'b0;
            m1_vld_reg <= 1'b0;
            for (int i = 0; i < FOLD_STEPS; i++) begin
                dv_vld_reg[i] <= 1'b0;
            end
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            m0_vld_reg <= in_valid;
            m1_vld_reg <= m0_vld_reg;
            dv_vld_reg[0] <= m1_vld_reg;
            for (int i = 1; i < FOLD_STEPS; i++) begin
                dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
            f1_vld_reg <= dv_vld_reg[FOLD_STEPS-1];
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_x_reg     <= m0_x_next;
            m0_delta_reg <= in_delta;

            m1_mag_reg   <= m1_mag_next[DELTA_W-1:0];
            m1_neg_reg   <= m0_x_reg[DELTA_W];
            m1_delta_reg <= m0_delta_reg;

            dv_rem_reg[0]   <= rem_step('0, m1_mag_reg[DELTA_W-1], len);
            dv_quo_reg[0]   <= m1_mag_reg << 1;
            dv_neg_reg[0]   <= m1_neg_reg;
            dv_delta_reg[0] <= m1_delta_reg;
            for (int i = 1; i < FOLD_STEPS; i++) begin
                dv_rem_reg[i]   <= rem_step(dv_rem_reg[i-1], dv_quo_reg[i-1][DELTA_W-1], len);
                dv_quo_reg[i]   <= dv_quo_reg[i-1] << 1;
                dv_neg_reg[i]   <= dv_neg_reg[i-1];
                dv_delta_reg[i] <= dv_delta_reg[i-1];
            end

            f1_r_reg     <= f1_r_next;
            f1_delta_reg <= dv_delta_reg[FOLD_STEPS-1];

            f2_out_reg <= f2_out_next;
        end
    end

    assign out_valid = f2_vld_reg;
    assign out_delta = f2_out_reg;

endmodule

/* rtl/pmid_isqrt.sv */
module pmid_isqrt import pmid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_value,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root
);

    typedef struct packed {
        logic [ROOT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } rt_step_t;

    function automatic rt_step_t root_step(input logic [ROOT_REM_W-1:0] rem,
                                           input logic [ROOT_W-1:0] root,
                                           input logic [1:0] pair);
        logic [ROOT_REM_W-1:0] shifted;
        logic [ROOT_REM_W-1:0] trial;
        rt_step_t              res;
        shifted = {rem[ROOT_REM_W-3:0], pair};
        trial   = ROOT_REM_W'({root, 2'b01});
        if (shifted >= trial) begin
            res.rem  = shifted - trial;
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = shifted;
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic                  rt_vld_reg  [ROOT_W];
    logic [ROOT_REM_W-1:0] rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]     rt_root_reg [ROOT_W];
    logic [SUM_W-1:0]      rt_num_reg  [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROOT_W; i++) begin
                rt_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            rt_vld_reg[0] <= in_valid;
            for (int i = 1; i < ROOT_W; i++) begin
                rt_vld_reg[i] <= rt_vld_reg[i-1];
            end
        end
    end

    // one result bit per stage, two radicand bits consumed per stage
    always_ff @(posedge aclk) begin
        if (en) begin
            {rt_rem_reg[0], rt_root_reg[0]} <=
                root_step('0, '0, in_value[SUM_W-1:SUM_W-2]);
            rt_num_reg[0] <= in_value << 2;
            for (int i = 1; i < ROOT_W; i++) begin
                {rt_rem_reg[i], rt_root_reg[i]} <=
                    root_step(rt_rem_reg[i-1], rt_root_reg[i-1],
                              rt_num_reg[i-1][SUM_W-1:SUM_W-2]);
                rt_num_reg[i] <= rt_num_reg[i-1] << 2;
            end
        end
    end

    assign out_valid = rt_vld_reg[ROOT_W-1];
    assign out_root  = rt_root_reg[ROOT_W-1];

endmodule

/* rtl/periodic_min_image_distance_core.sv */
// Minimum-image distance between two 3-D points in signed Q16.16. Each axis
// difference is folded into [-floor(L/2), L - floor(L/2)) when its wrap_mask bit
// is set and its length is nonzero; the result is the truncated Euclidean
// distance in unsigned Q17.16. One point pair is taken every cycle unless
// backpressure on the result channel freezes the whole pipeline. The path to
// the result holds one difference stage, 37 fold stages (a 33-step pipelined
// remainder unit per axis), three square-and-sum stages, 33 square-root stages
// and the output register. Registers live on the APB port at byte offsets 0x0
// (length_x), 0x4 (length_y), 0x8 (length_z), 0xC (wrap_mask); the user must
// write them only while no transaction is in flight (not enforced by the block).
module periodic_min_image_distance_core import pmid_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_first_x,
    input  logic signed [COORD_W-1:0] s_first_y,
    input  logic signed [COORD_W-1:0] s_first_z,
    input  logic signed [COORD_W-1:0] s_second_x,
    input  logic signed [COORD_W-1:0] s_second_y,
    input  logic signed [COORD_W-1:0] s_second_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ROOT_W-1:0]         m_separation
);

    cfg_t                          cfg;
    logic                          en;
    logic [MAX_AXES-1:0][COORD_W-1:0] first_w;
    logic [MAX_AXES-1:0][COORD_W-1:0] second_w;

    logic                          t0_vld_reg;
    logic [DELTA_W-1:0]            delta_reg [AXES];

    logic [AXES-1:0]               fold_vld;
    logic [DELTA_W-1:0]            fold_out  [AXES];

    logic                          s0_vld_reg;
    logic [MAG_W-1:0]              ab_reg    [AXES];
    logic                          s1_vld_reg;
    logic [SQ_W-1:0]               sq_reg    [AXES];
    logic                          s2_vld_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;

    logic                          rt_vld;
    logic [ROOT_W-1:0]             rt_root;

    logic                          m_valid_reg;
    logic [ROOT_W-1:0]             m_separation_reg;

    pmid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance everything unless a finished result is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign first_w  = {s_first_z, s_first_y, s_first_x};
    assign second_w = {s_second_z, s_second_y, s_second_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
        end else if (en) begin
            t0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < AXES; d++) begin
                delta_reg[d] <= {second_w[d][COORD_W-1], second_w[d]}
                              - {first_w[d][COORD_W-1], first_w[d]};
            end
        end
    end

    for (genvar d = 0; d < AXES; d++) begin : g_axis
        pmid_fold u_fold (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (t0_vld_reg),
            .in_delta  (delta_reg[d]),
            .len       (cfg.len[d]),
            .wrap      (cfg.wrap[d]),
            .out_valid (fold_vld[d]),
            .out_delta (fold_out[d])
        );
    end

    always_comb begin
        sum_next = '0;
        for (int d = 0; d < AXES; d++) begin
            sum_next = sum_next + SUM_W'(sq_reg[d]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= &fold_vld;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < AXES; d++) begin
                ab_reg[d] <= fold_out[d][DELTA_W-1] ? MAG_W'(~fold_out[d] + 1'b1)
                                                    : fold_out[d][MAG_W-1:0];
                sq_reg[d] <= ab_reg[d] * ab_reg[d];
            end
            sum_reg <= sum_next;
        end
    end

    pmid_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_vld_reg),
        .in_value  (sum_reg),
        .out_valid (rt_vld),
        .out_root  (rt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rt_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_separation_reg <= rt_root;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_separation = m_separation_reg;

endmodule

/* bench/tb_periodic_min_image_distance_core.sv */
module tb_periodic_min_image_distance_core;
    import pmid_pkg::*;

    localparam int LATENCY = 75;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1950;

    typedef struct packed {
        logic signed [COORD_W-1:0] fx, fy, fz, sx, sy, sz;
    } pair_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_first_x = '0, s_first_y = '0, s_first_z = '0;
    logic signed [COORD_W-1:0] s_second_x = '0, s_second_y = '0, s_second_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ROOT_W-1:0] m_separation;

    periodic_min_image_distance_core uut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // mirror of the block's registers
    logic [LEN_W-1:0]  dom_len [3];
    logic [MASK_W-1:0] dom_wrap;

    pair_t pending_pairs [$];
    logic [ROOT_W-1:0] expected_dist [$];
    int errors = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit drive_done = 1'b0;

    // append one pair to the tail of the pending queue
    task automatic add_pair(pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    function automatic logic signed [63:0] fold_delta(logic signed [63:0] d,
                                                      logic [LEN_W-1:0] len);
        logic signed [63:0] l, h, r;
        l = {33'd0, len};
        h = l / 2;
        if (l == 0) return d;
        r = (d + h) % l;
        if (r < 0) r += l;
        return r - h;
    endfunction

    function automatic logic [ROOT_W-1:0] min_image_dist(pair_t p);
        logic signed [63:0] d [3];
        logic [127:0] acc, mag, cand;
        logic [ROOT_W-1:0] root;
        d[0] = 64'(p.sx) - 64'(p.fx);
        d[1] = 64'(p.sy) - 64'(p.fy);
        d[2] = 64'(p.sz) - 64'(p.fz);
        acc = '0;
        for (int a = 0; a < AXES; a++) begin
            if (dom_wrap[a]) d[a] = fold_delta(d[a], dom_len[a]);
            mag = d[a] < 0 ? 128'(-d[a]) : 128'(d[a]);
            acc += mag * mag;
        end
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            cand = 128'(root | (ROOT_W'(1) << b));
            if (cand * cand <= acc) root = root | (ROOT_W'(1) << b);
        end
        return root;
    endfunction

    // driver: predict at acceptance so configuration matches the in-flight items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_dist.insert(expected_dist.size(),
                                     min_image_dist({s_first_x, s_first_y, s_first_z,
                                                     s_second_x, s_second_y, s_second_z}));
                void'(pending_pairs.pop_front());
            end
            // hold a waiting transaction; otherwise load the next one or idle
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    {s_first_x, s_first_y, s_first_z, s_second_x, s_second_y, s_second_z}
                        <= pending_pairs[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_dist.size() == 0) begin
                $error("separation: unexpected transaction, actual %0h", m_separation);
                errors++;
            end else begin
                if (m_separation !== expected_dist[0]) begin
                    $error("separation: expected %0h actual %0h",
                           expected_dist[0], m_separation);
                    errors++;
                end
                void'(expected_dist.pop_front());
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel ||
            (pending_pairs.size() == 0 && expected_dist.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LEN_X: dom_len[0] = value[LEN_W-1:0];
            REG_LEN_Y: dom_len[1] = value[LEN_W-1:0];
            REG_LEN_Z: dom_len[2] = value[LEN_W-1:0];
            REG_WRAP:  dom_wrap = value[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || s_valid || expected_dist.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $signed(32'h8000_0000 + $urandom_range(15));
            1: return $signed(32'h7FFF_FFFF - $urandom_range(15));
            2: return $signed(32'($urandom_range(8'hFF)) - 128);
            default: return $signed($urandom);
        endcase
    endfunction

    // point inside [0, len) so the fold is exercised near its window edges
    function automatic logic signed [COORD_W-1:0] rand_in_domain(logic [LEN_W-1:0] len);
        if (len == 0) return rand_coord();
        return $signed(32'($urandom % len));
    endfunction

    task automatic queue_random(int n);
        pair_t p;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) != 0) begin
                p.fx = rand_in_domain(dom_len[0]); p.sx = rand_in_domain(dom_len[0]);
                p.fy = rand_in_domain(dom_len[1]); p.sy = rand_in_domain(dom_len[1]);
                p.fz = rand_in_domain(dom_len[2]); p.sz = rand_in_domain(dom_len[2]);
            end else begin
                p = {rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord()};
            end
            add_pair(p);
        end
    endtask

    task automatic run_setting(logic [30:0] lx, logic [30:0] ly, logic [30:0] lz,
                               logic [2:0] wm, int n);
        write_reg(REG_LEN_X, {1'b0, lx});
        write_reg(REG_LEN_Y, {1'b0, ly});
        write_reg(REG_LEN_Z, {1'b0, lz});
        write_reg(REG_WRAP, {29'd0, wm});
        queue_random(n);
        drain();
    endtask

    localparam logic signed [31:0] MINC = 32'sh8000_0000;
    localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;

    initial begin
        dom_len[0] = LEN_RESET; dom_len[1] = LEN_RESET; dom_len[2] = LEN_RESET;
        dom_wrap = WRAP_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 24; recv_idle_pct = 74;

        // directed: reset setting, extremes of every field
        add_pair({MINC, MINC, MINC, MAXC, MAXC, MAXC});
        add_pair({MAXC, MAXC, MAXC, MINC, MINC, MINC});
        add_pair({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        add_pair({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0});
        add_pair({-32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0});
        drain();

        // wrap with odd length and window edges; out-of-domain points
        write_reg(REG_LEN_X, 32'd65537);
        write_reg(REG_LEN_Y, 32'd0);
        write_reg(REG_LEN_Z, 32'h7FFF_FFFF);
        write_reg(REG_WRAP, 32'd7);
        add_pair({32'sd0, 32'sd0, 32'sd0, 32'sd32768, MAXC, MAXC});
        add_pair({32'sd0, MINC, MINC, -32'sd32768, MAXC, MAXC});
        add_pair({32'sd0, 32'sd0, 32'sd0, 32'sd32769, 32'sd5, -32'sd1});
        add_pair({32'sd0, 32'sd0, MINC, -32'sd32769, 32'sd5, MAXC});
        add_pair({MINC, 32'sd0, 32'sd0, MAXC, 32'sd0, MINC});
        add_pair({MAXC, 32'sd0, MAXC, MINC, 32'sd0, MINC});
        add_pair({32'sd65537, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        drain();
        write_reg(REG_LEN_X, 32'd1);
        write_reg(REG_LEN_Y, 32'd2);
        write_reg(REG_LEN_Z, 32'd3);
        add_pair({MINC, MINC, MINC, MAXC, MAXC, MAXC});
        add_pair({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd2});
        drain();

        run_setting(31'd65536, 31'd131072, 31'd196608, 3'b101, 350);
        run_setting(31'h7FFF_FFFF, 31'h4000_0001, 31'd12345, 3'b111, 300);
        send_idle_pct = 74; recv_idle_pct = 24;
        run_setting(31'd0, 31'd1, 31'h7FFF_FFFF, 3'b011, 300);
        run_setting(31'($urandom), 31'($urandom), 31'($urandom), 3'b110, 300);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_setting(31'($urandom_range(1 << 20)), 31'($urandom), 31'd3, 3'b111, 350);
        run_setting(31'd65536, 31'd65536, 31'd65536, 3'b000, 350);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/pmid_pkg.sv
rtl/pmid_regs.sv
rtl/pmid_fold.sv
rtl/pmid_isqrt.sv
rtl/periodic_min_image_distance_core.sv
bench/tb_periodic_min_image_distance_core.sv
